>>> hdl/gdrf_pkg.sv
// Shared types, widths and constants of the geo distance range filter.
// Also holds the elaboration-time function for the cos^2 table contents.
// No dependencies.
package gdrf_pkg;

   localparam int INDEX_W = 16;
   localparam int LAT_W = 30;
   localparam int LON_W = 31;
   localparam int DIST_W = 20;
   localparam int CSR_DATA_W = 31;
   localparam int COS_W = 16;

   localparam int COS_TABLE_ADDR_BITS_DEFAULT = 10;
   localparam int ANGLE_FRAC_BITS_DEFAULT = 28;

   localparam logic [LAT_W-1:0] REF_LATITUDE_RESET = '0;
   localparam logic [LON_W-1:0] REF_LONGITUDE_RESET = '0;
   localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = DIST_W'(50);
   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = DIST_W'(35000);

   // Earth radius squared in square meters (6371000^2)
   localparam int EARTH_R_SQ_W = 46;
   localparam logic [EARTH_R_SQ_W-1:0] EARTH_R_SQ = 46'd40589641000000;

   localparam int TAYLOR_TERMS = 12;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

   typedef enum logic [1:0] {
      CSR_REF_LATITUDE  = 2'd0,
      CSR_REF_LONGITUDE = 2'd1,
      CSR_MIN_DISTANCE  = 2'd2,
      CSR_MAX_DISTANCE  = 2'd3
   } csr_index_type;

   // cos^2 at the bin midpoint (2*entry+1)/2^addr_bits rad, Q0.16
   function automatic logic [COS_W-1:0] cos_sq_entry(input int unsigned entry,
                                                     input int unsigned addr_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned mag;
      longint unsigned sq;
      longint unsigned e;
      longint acc;
      x = 64'(2 * entry + 1) << (30 - addr_bits);
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      acc = 64'sd1 <<< 30;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         t = ((t * x2) >> 30) / TAYLOR_DIV[n-1];
         if ((n & 1) == 1) begin
            acc = acc - $signed(t);
         end else begin
            acc = acc + $signed(t);
         end
      end
      mag = (acc < 0) ? $unsigned(-acc) : $unsigned(acc);
      sq = mag * mag;
      e = (sq + (64'd1 << 43)) >> 44;
      if (e > 64'd65535) begin
         e = 64'd65535;
      end
      return e[COS_W-1:0];
   endfunction

endpackage

>>> hdl/gdrf_req_if.sv
// Request channel of the geo distance range filter: one point per request.
// Depends on gdrf_pkg for field widths.
interface gdrf_req_if import gdrf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [INDEX_W-1:0]       point_index;
   logic signed [LAT_W-1:0]  point_latitude;
   logic signed [LON_W-1:0]  point_longitude;

   modport source (output valid, point_index, point_latitude, point_longitude,
                   input ready);
   modport sink (input valid, point_index, point_latitude, point_longitude,
                 output ready);
endinterface

>>> hdl/gdrf_rsp_if.sv
// Response channel of the geo distance range filter: index of an in-range point.
// Depends on gdrf_pkg for field widths.
interface gdrf_rsp_if import gdrf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] accepted_index;

   modport source (output valid, accepted_index, input ready);
   modport sink (input valid, accepted_index, output ready);
endinterface

>>> hdl/gdrf_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module gdrf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_a_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data_ff <= mem_ff[rd_a_addr];
      end
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;
endmodule

>>> hdl/geo_distance_range_filter_unit.sv
// Geo distance range filter: equirectangular distance test of points against a band.
// Depends on gdrf_pkg, gdrf_req_if, gdrf_rsp_if and gdrf_ram.
//
//   Channel  Dir  Handshake        Payload
//   req      in   valid/ready      point_index, point_latitude, point_longitude
//   rsp      out  valid/ready      accepted_index (only for points inside the band)
//   csr      in   csr_wr_en        csr_index, csr_wr_data
//
// One request per cycle while rsp is not stalled; a result passes through the ten register
// stages of the multiply and compare chain. Rejected points leave no result.
// After reset, req.ready stays low while all 2^COS_TABLE_ADDR_BITS entries of the
// cos^2 table are filled. A stalled rsp freezes the whole pipeline and the request side.
module geo_distance_range_filter_unit import gdrf_pkg::*; #(
   parameter int COS_TABLE_ADDR_BITS = COS_TABLE_ADDR_BITS_DEFAULT,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   gdrf_req_if.sink              req,
   gdrf_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   localparam int ADDR_W = COS_TABLE_ADDR_BITS;
   localparam int TABLE_DEPTH = 1 << ADDR_W;
   localparam int LOOKUP_SHIFT = ANGLE_FRAC_BITS + 1 - ADDR_W;
   localparam int BOUND_SHIFT = 2 * ANGLE_FRAC_BITS;

   localparam int DLAT_W = LAT_W + 1;
   localparam int ADLAT_W = LAT_W;
   localparam int DLAT2_W = 2 * ADLAT_W;
   localparam int DLON_W = LON_W + 1;
   localparam int ADLON_W = LON_W;
   localparam int DLON2_W = 2 * ADLON_W;
   localparam int DLON2_HI_W = DLON2_W - 32;
   localparam int PP_HI_W = DLON2_HI_W + COS_W;
   localparam int PP_LO_W = 32 + COS_W;
   localparam int TERM_W = DLON2_W;
   localparam int S_W = TERM_W + 1;
   localparam int S_HI_W = S_W - 32;
   localparam int R_LO_W = 23;
   localparam int R_HI_W = EARTH_R_SQ_W - R_LO_W;
   localparam int LL_W = 32 + R_LO_W;
   localparam int LH_W = 32 + R_HI_W;
   localparam int HL_W = S_HI_W + R_LO_W;
   localparam int HH_W = S_HI_W + R_HI_W;
   localparam int SUM_A_W = LH_W + R_LO_W;
   localparam int SUM_B_W = HH_W + R_LO_W;
   localparam int PROD_W = SUM_B_W + 32;
   localparam int DSQ_W = 2 * DIST_W;

   localparam logic [R_LO_W-1:0] EARTH_R_SQ_LO = EARTH_R_SQ[R_LO_W-1:0];
   localparam logic [R_HI_W-1:0] EARTH_R_SQ_HI = EARTH_R_SQ[EARTH_R_SQ_W-1:R_LO_W];

   function automatic logic [ADDR_W-1:0] cos_addr(input logic signed [LAT_W-1:0] lat);
      logic [LAT_W-1:0] mag;
      logic [LAT_W-1:0] bin;
      mag = lat[LAT_W-1] ? LAT_W'(-lat) : LAT_W'(lat);
      bin = mag >> LOOKUP_SHIFT;
      return (bin > LAT_W'(TABLE_DEPTH - 1)) ? '1 : bin[ADDR_W-1:0];
   endfunction

   // Configuration registers
   logic signed [LAT_W-1:0] ref_lat_ff;
   logic signed [LON_W-1:0] ref_lon_ff;
   logic [DIST_W-1:0]       min_dist_ff;
   logic [DIST_W-1:0]       max_dist_ff;
   logic [DSQ_W-1:0]        min_sq_ff;
   logic [DSQ_W-1:0]        max_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff <= REF_LATITUDE_RESET;
         ref_lon_ff <= REF_LONGITUDE_RESET;
         min_dist_ff <= MIN_DISTANCE_RESET;
         max_dist_ff <= MAX_DISTANCE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REF_LATITUDE:  ref_lat_ff <= csr_wr_data[LAT_W-1:0];
            CSR_REF_LONGITUDE: ref_lon_ff <= csr_wr_data[LON_W-1:0];
            CSR_MIN_DISTANCE:  min_dist_ff <= csr_wr_data[DIST_W-1:0];
            CSR_MAX_DISTANCE:  max_dist_ff <= csr_wr_data[DIST_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      min_sq_ff <= DSQ_W'(min_dist_ff) * DSQ_W'(min_dist_ff);
      max_sq_ff <= DSQ_W'(max_dist_ff) * DSQ_W'(max_dist_ff);
   end

   // cos^2 table fill after reset
   logic [COS_W-1:0]  cos_init [TABLE_DEPTH];
   logic              fill_active_ff;
   logic [ADDR_W-1:0] fill_addr_ff;

   for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cos_init
      localparam logic [COS_W-1:0] ENTRY_VALUE = cos_sq_entry(gi, COS_TABLE_ADDR_BITS);
      assign cos_init[gi] = ENTRY_VALUE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_active_ff <= 1'b1;
         fill_addr_ff <= '0;
      end else if (fill_active_ff) begin
         fill_addr_ff <= fill_addr_ff + 1'b1;
         if (fill_addr_ff == '1) begin
            fill_active_ff <= 1'b0;
         end
      end
   end

   // Pipeline control
   logic       advance;
   logic [9:1] vld_ff;
   logic [9:1] vld_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance && !fill_active_ff;

   logic [COS_W-1:0] cos_point;
   logic [COS_W-1:0] cos_ref;

   gdrf_ram #(
      .WIDTH(COS_W),
      .DEPTH(TABLE_DEPTH)
   ) u_cos_ram (
      .clock    (clock),
      .wr_en    (fill_active_ff),
      .wr_addr  (fill_addr_ff),
      .wr_data  (cos_init[fill_addr_ff]),
      .rd_a_en  (advance),
      .rd_a_addr(cos_addr(req.point_latitude)),
      .rd_a_data(cos_point),
      .rd_b_addr(cos_addr(ref_lat_ff)),
      .rd_b_data(cos_ref)
   );

   // Stage registers
   logic [INDEX_W-1:0]       idx_ff [1:10];
   logic [INDEX_W-1:0]       idx_in [1:10];
   logic signed [DLAT_W-1:0] dlat_ff, dlat_in;
   logic signed [DLON_W-1:0] dlon_ff, dlon_in;
   logic [ADLAT_W-1:0]       adlat_ff, adlat_in;
   logic [ADLON_W-1:0]       adlon_ff, adlon_in;
   logic [COS_W-1:0]         c01_ff, c01_in;
   logic [COS_W-1:0]         c01_d_ff;
   logic [DLAT2_W-1:0]       dlat2_ff [3:5];
   logic [DLAT2_W-1:0]       dlat2_in;
   logic [DLON2_W-1:0]       dlon2_ff, dlon2_in;
   logic [PP_HI_W-1:0]       pp_hi_ff, pp_hi_in;
   logic [PP_LO_W-1:0]       pp_lo_ff, pp_lo_in;
   logic [TERM_W-1:0]        term_ff, term_in;
   logic [S_W-1:0]           s_ff, s_in;
   logic [LL_W-1:0]          ll_ff, ll_in;
   logic [LH_W-1:0]          lh_ff, lh_in;
   logic [HL_W-1:0]          hl_ff, hl_in;
   logic [HH_W-1:0]          hh_ff, hh_in;
   logic [SUM_A_W-1:0]       sum_a_ff, sum_a_in;
   logic [SUM_B_W-1:0]       sum_b_ff, sum_b_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [PROD_W-1:0]        bound_min;
   logic [PROD_W-1:0]        bound_max;
   logic [33:0]              c01_round;

   always_comb begin
      vld_in = {vld_ff[8:1], req.valid && req.ready};
      idx_in[1] = req.point_index;
      for (int k = 2; k <= 10; k++) begin
         idx_in[k] = idx_ff[k-1];
      end

      dlat_in = DLAT_W'(req.point_latitude) - DLAT_W'(ref_lat_ff);
      dlon_in = DLON_W'(req.point_longitude) - DLON_W'(ref_lon_ff);

      adlat_in = dlat_ff[DLAT_W-1] ? ADLAT_W'(-dlat_ff) : ADLAT_W'(dlat_ff);
      adlon_in = dlon_ff[DLON_W-1] ? ADLON_W'(-dlon_ff) : ADLON_W'(dlon_ff);
      c01_round = 34'(cos_ref) * 34'(cos_point) + 34'(32768);
      c01_in = c01_round[COS_W+15:16];

      dlat2_in = DLAT2_W'(adlat_ff) * DLAT2_W'(adlat_ff);
      dlon2_in = DLON2_W'(adlon_ff) * DLON2_W'(adlon_ff);

      pp_hi_in = PP_HI_W'(dlon2_ff[DLON2_W-1:32]) * PP_HI_W'(c01_d_ff);
      pp_lo_in = PP_LO_W'(dlon2_ff[31:0]) * PP_LO_W'(c01_d_ff);

      term_in = TERM_W'({pp_hi_ff, 16'd0}) + TERM_W'(pp_lo_ff[PP_LO_W-1:16]);

      s_in = S_W'(term_ff) + S_W'(dlat2_ff[5]);

      ll_in = LL_W'(s_ff[31:0]) * LL_W'(EARTH_R_SQ_LO);
      lh_in = LH_W'(s_ff[31:0]) * LH_W'(EARTH_R_SQ_HI);
      hl_in = HL_W'(s_ff[S_W-1:32]) * HL_W'(EARTH_R_SQ_LO);
      hh_in = HH_W'(s_ff[S_W-1:32]) * HH_W'(EARTH_R_SQ_HI);

      sum_a_in = SUM_A_W'(ll_ff) + {lh_ff, {R_LO_W{1'b0}}};
      sum_b_in = SUM_B_W'(hl_ff) + {hh_ff, {R_LO_W{1'b0}}};

      prod_in = PROD_W'(sum_a_ff) + {sum_b_ff, 32'd0};

      bound_min = PROD_W'(min_sq_ff) << BOUND_SHIFT;
      bound_max = PROD_W'(max_sq_ff) << BOUND_SHIFT;
      rsp_valid_in = vld_ff[9] && (prod_ff > bound_min) && (prod_ff < bound_max);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff <= idx_in;
         dlat_ff <= dlat_in;
         dlon_ff <= dlon_in;
         adlat_ff <= adlat_in;
         adlon_ff <= adlon_in;
         c01_ff <= c01_in;
         c01_d_ff <= c01_ff;
         dlat2_ff[3] <= dlat2_in;
         dlat2_ff[4] <= dlat2_ff[3];
         dlat2_ff[5] <= dlat2_ff[4];
         dlon2_ff <= dlon2_in;
         pp_hi_ff <= pp_hi_in;
         pp_lo_ff <= pp_lo_in;
         term_ff <= term_in;
         s_ff <= s_in;
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         prod_ff <= prod_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.accepted_index = idx_ff[10];

   a_no_request_during_fill: assert property (@(posedge clock) disable iff (reset)
      fill_active_ff |-> !req.ready)
      else $error("request taken while cos table fill is running");

   a_fill_ends: assert property (@(posedge clock) disable iff (reset)
      fill_active_ff && (fill_addr_ff == '1) |=> !fill_active_ff)
      else $error("cos table fill did not end after last entry");

   a_bubble_gives_no_result: assert property (@(posedge clock) disable iff (reset)
      advance && !vld_ff[9] |=> !rsp.valid)
      else $error("result produced from an empty pipeline slot");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff) && $stable(prod_ff) && $stable(s_ff))
      else $error("pipeline moved while the result was stalled");
endmodule
